@@ hw/rtl/mrat_pkg.sv @@
package mrat_pkg;

	localparam int FIELD_ADDR_W = 48;
	localparam int PROT_W = 8;
	localparam int FLAG_W = 16;
	localparam int COUNT_W = 7;

	typedef logic [1:0] mode_t;
	localparam mode_t MODE_MAP = 2'd0;
	localparam mode_t MODE_UNMAP = 2'd1;
	localparam mode_t MODE_PROTECT = 2'd2;
	localparam mode_t MODE_UNUSED = 2'd3;

	typedef logic [1:0] status_t;
	localparam status_t ST_DONE = 2'd0;
	localparam status_t ST_FULL = 2'd1;
	localparam status_t ST_RANGE = 2'd2;

	typedef struct packed {
		logic valid;
		status_t status;
		logic [COUNT_W-1:0] count;
	} rsp_t;

endpackage

@@ hw/rtl/mrat_if.sv @@
interface mrat_req_if;
	import mrat_pkg::*;
	logic valid;
	logic ready;
	mode_t mode;
	logic [FIELD_ADDR_W-1:0] base_address;
	logic [FIELD_ADDR_W-1:0] range_length;
	logic [PROT_W-1:0] protection;
	logic [FLAG_W-1:0] map_flags;
	modport source (output valid, mode, base_address, range_length, protection, map_flags,
		input ready);
	modport sink (input valid, mode, base_address, range_length, protection, map_flags,
		output ready);
endinterface

interface mrat_rsp_if;
	import mrat_pkg::*;
	logic valid;
	logic ready;
	status_t status;
	logic [COUNT_W-1:0] region_count;
	modport source (output valid, status, region_count, input ready);
	modport sink (input valid, status, region_count, output ready);
endinterface

@@ hw/rtl/mrat_mem.sv @@
module mrat_mem #(
	parameter int AW = 7,
	parameter int DW = 8
) (
	input  logic clk,
	input  logic we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ hw/rtl/mrat_engine.sv @@
module mrat_engine #(
	parameter int MAX_REGIONS = 64,
	parameter int ADDR_BITS = 48
) (
	input  logic clk,
	input  logic arst_n,
	mrat_req_if.sink req,
	output mrat_pkg::rsp_t resp,
	input  logic resp_ack,
	output logic mem_we,
	output logic [$clog2(MAX_REGIONS):0] mem_waddr,
	output logic [2*ADDR_BITS+mrat_pkg::PROT_W+mrat_pkg::FLAG_W-1:0] mem_wdata,
	output logic [$clog2(MAX_REGIONS):0] mem_raddr,
	input  logic [2*ADDR_BITS+mrat_pkg::PROT_W+mrat_pkg::FLAG_W-1:0] mem_rdata
);
	import mrat_pkg::*;

	localparam int AW = ADDR_BITS;
	localparam int IW = $clog2(MAX_REGIONS);
	localparam int UW = $clog2(MAX_REGIONS + 1);
	localparam int CW = $clog2(3 * MAX_REGIONS + 2);
	localparam logic [64:0] AMASK = (65'd1 << ADDR_BITS) - 65'd1;

	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_CHK = 10'b0000000010,
		S_SCAN_RD = 10'b0000000100,
		S_SCAN_EV = 10'b0000001000,
		S_DECIDE = 10'b0000010000,
		S_WALK_RD = 10'b0000100000,
		S_WALK_EV = 10'b0001000000,
		S_EMIT = 10'b0010000000,
		S_FIN = 10'b0100000000,
		S_RESP = 10'b1000000000
	} state_t;

	state_t state_q;
	mode_t mode_q;
	logic [FIELD_ADDR_W-1:0] base_q, len_q;
	logic [PROT_W-1:0] prot_q;
	logic [FLAG_W-1:0] fl_q;
	logic [AW-1:0] s_q, e_q;
	logic [IW-1:0] idx_q, w_q;
	logic [UW-1:0] used_q;
	logic [CW-1:0] cnt_q;
	logic bank_q, any_q, placed_q;
	status_t status_q;
	logic [COUNT_W-1:0] count_q;
	logic [3:0] mask_q;
	logic [AW-1:0] rs_q, re_q;
	logic [PROT_W-1:0] rp_q;
	logic [FLAG_W-1:0] rf_q;
	logic keep_q;

	logic [AW-1:0] rs, re;
	logic [PROT_W-1:0] rp;
	logic [FLAG_W-1:0] rf, newf;
	logic hit, eq, split, p_left, p_mid, p_right, p_ins, last;
	logic [64:0] sum_w, base_w;
	logic need_ins;
	logic [CW-1:0] total;

	assign {rs, re, rp, rf} = mem_rdata;
	assign newf = (mode_q == MODE_MAP) ? fl_q : rf;
	assign hit = (rs < e_q) && (s_q < re);
	assign eq = (rp == prot_q) && (rf == newf);
	assign split = hit && ((mode_q == MODE_UNMAP) || !eq);
	assign p_left = split && (rs < s_q);
	assign p_right = split && (e_q < re);
	assign p_mid = !hit || (mode_q != MODE_UNMAP);
	assign need_ins = (mode_q == MODE_MAP) && !any_q;
	assign p_ins = need_ins && !placed_q && (rs >= s_q);
	assign last = (UW'(idx_q) + UW'(1)) == used_q;
	assign base_w = {17'd0, base_q};
	assign sum_w = base_w + {17'd0, len_q};
	assign total = cnt_q + CW'(need_ins);

	assign req.ready = (state_q == S_IDLE);
	assign mem_raddr = {bank_q, idx_q};
	assign mem_waddr = {~bank_q, w_q};

	always_comb begin
		mem_we = 1'b0;
		mem_wdata = {s_q, e_q, prot_q, fl_q};
		if (state_q == S_EMIT) begin
			mem_we = 1'b1;
			if (mask_q[0]) begin
				mem_wdata = {s_q, e_q, prot_q, fl_q};
			end else if (mask_q[1]) begin
				mem_wdata = {rs_q, s_q, rp_q, rf_q};
			end else if (mask_q[2]) begin
				if (keep_q) begin
					mem_wdata = {rs_q, re_q, rp_q, rf_q};
				end else begin
					mem_wdata = {(rs_q < s_q) ? s_q : rs_q, (re_q < e_q) ? re_q : e_q,
						prot_q, (mode_q == MODE_MAP) ? fl_q : rf_q};
				end
			end else begin
				mem_wdata = {e_q, re_q, rp_q, rf_q};
			end
		end else if (state_q == S_FIN) begin
			mem_we = need_ins && !placed_q;
		end
	end

	assign resp.valid = (state_q == S_RESP);
	assign resp.status = status_q;
	assign resp.count = count_q;

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid) begin
			mode_q <= req.mode;
			base_q <= req.base_address;
			len_q <= req.range_length;
			prot_q <= req.protection;
			fl_q <= req.map_flags;
		end
		if (state_q == S_CHK) begin
			s_q <= AW'(base_q);
			e_q <= sum_w[AW-1:0];
		end
		if (state_q == S_WALK_EV) begin
			rs_q <= rs;
			re_q <= re;
			rp_q <= rp;
			rf_q <= rf;
			keep_q <= !hit || eq;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q <= '0;
			bank_q <= 1'b0;
			idx_q <= '0;
			w_q <= '0;
			cnt_q <= '0;
			any_q <= 1'b0;
			placed_q <= 1'b0;
			mask_q <= '0;
			status_q <= ST_DONE;
			count_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					idx_q <= '0;
					cnt_q <= '0;
					any_q <= 1'b0;
					count_q <= COUNT_W'(used_q);
					status_q <= ST_DONE;
					if (mode_q == MODE_UNUSED || len_q == '0) begin
						state_q <= S_RESP;
					end else if (base_w > AMASK || sum_w > AMASK) begin
						status_q <= ST_RANGE;
						state_q <= S_RESP;
					end else if (used_q == '0) begin
						state_q <= S_DECIDE;
					end else begin
						state_q <= S_SCAN_RD;
					end
				end
				S_SCAN_RD: state_q <= S_SCAN_EV;
				S_SCAN_EV: begin
					any_q <= any_q | hit;
					cnt_q <= cnt_q + CW'(p_left) + CW'(p_mid) + CW'(p_right);
					idx_q <= idx_q + IW'(1);
					state_q <= last ? S_DECIDE : S_SCAN_RD;
				end
				S_DECIDE: begin
					idx_q <= '0;
					w_q <= '0;
					placed_q <= 1'b0;
					if (total > CW'(MAX_REGIONS)) begin
						status_q <= ST_FULL;
						state_q <= S_RESP;
					end else if (used_q == '0) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_WALK_RD;
					end
				end
				S_WALK_RD: state_q <= S_WALK_EV;
				S_WALK_EV: begin
					mask_q <= {p_right, p_mid, p_left, p_ins};
					if (p_ins) begin
						placed_q <= 1'b1;
					end
					if (p_ins || p_left || p_mid || p_right) begin
						state_q <= S_EMIT;
					end else begin
						idx_q <= idx_q + IW'(1);
						state_q <= last ? S_FIN : S_WALK_RD;
					end
				end
				S_EMIT: begin
					// drop the piece just written, lowest first
					mask_q <= mask_q & (mask_q - 4'd1);
					w_q <= w_q + IW'(1);
					if ((mask_q & (mask_q - 4'd1)) == 4'd0) begin
						idx_q <= idx_q + IW'(1);
						state_q <= last ? S_FIN : S_WALK_RD;
					end
				end
				S_FIN: begin
					bank_q <= ~bank_q;
					used_q <= UW'(total);
					count_q <= COUNT_W'(total);
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (resp_ack) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ hw/rtl/memory_region_attribute_table.sv @@
// Memory region attribute table.
// Requests enter on req (valid/ready): mode, base_address, range_length,
// protection and map_flags. Each request gives one item on rsp with a status
// and the region count after the request.
// Regions live in a two-bank memory: the current table is read from one bank
// while the rewritten table is built in the other, then the banks swap.
// A request is checked first; then each held region is read and scanned for
// overlap, the engine decides whether the result fits, each region is read
// again and its pieces are written to the other bank, the banks swap and the
// item goes to the output register. Zero-length, unused-mode and out-of-range
// requests go from the check straight to the response; a full-table reject
// ends after the decide step. The pieces written never exceed MAX_REGIONS.
// The single memory read port is used once per region in each pass.
// One request is in work at a time; req.ready is high only while idle, which
// is the cycle after the result leaves the engine.
// The result sits in an output register; a stalled rsp holds it, and the
// engine may finish the next request but holds it until the register frees.
// Reset empties the table (count zero); the memory itself is not cleared.
module memory_region_attribute_table #(
	parameter int MAX_REGIONS = 64,
	parameter int ADDR_BITS = 48
) (
	input  logic clk,
	input  logic arst_n,
	mrat_req_if.sink req,
	mrat_rsp_if.source rsp
);
	import mrat_pkg::*;

	localparam int IW = $clog2(MAX_REGIONS);
	localparam int DW = 2 * ADDR_BITS + PROT_W + FLAG_W;

	rsp_t resp;
	logic resp_ack;
	logic mem_we;
	logic [IW:0] mem_waddr, mem_raddr;
	logic [DW-1:0] mem_wdata, mem_rdata;
	logic out_v_q;
	status_t status_q;
	logic [COUNT_W-1:0] count_q;

	mrat_engine #(.MAX_REGIONS(MAX_REGIONS), .ADDR_BITS(ADDR_BITS)) u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.resp(resp),
		.resp_ack(resp_ack),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	mrat_mem #(.AW(IW + 1), .DW(DW)) u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign resp_ack = resp.valid && (!out_v_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (resp_ack) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (resp_ack) begin
			status_q <= resp.status;
			count_q <= resp.count;
		end
	end

	assign rsp.valid = out_v_q;
	assign rsp.status = status_q;
	assign rsp.region_count = count_q;
endmodule

@@ sim/memory_region_attribute_table_tb.sv @@
`timescale 1ns / 1ps

module memory_region_attribute_table_tb;
	import mrat_pkg::*;

	localparam int DEPTH = 64;
	localparam logic [63:0] ADDR_MAX = 64'hFFFF_FFFF_FFFF;

	typedef struct {
		mode_t mode;
		logic [47:0] base;
		logic [47:0] len;
		logic [7:0] prot;
		logic [15:0] flags;
		bit known;
		status_t st;
		logic [6:0] cnt;
	} req_row_t;

	typedef struct {
		status_t st;
		logic [6:0] cnt;
	} answer_t;

	logic clk;
	logic arst_n;
	bit failed;
	bit last_seen;

	mrat_req_if req ();
	mrat_rsp_if rsp ();

	memory_region_attribute_table uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	// mirror of the region table
	logic [63:0] tbl_start [$];
	logic [63:0] tbl_end [$];
	logic [7:0] tbl_prot [$];
	logic [15:0] tbl_flags [$];
	answer_t pending [$];

	logic [63:0] nx_s [$];
	logic [63:0] nx_e [$];
	logic [7:0] nx_p [$];
	logic [15:0] nx_f [$];

	function automatic void put(logic [63:0] s, logic [63:0] e, logic [7:0] p,
			logic [15:0] f);
		nx_s.push_back(s);
		nx_e.push_back(e);
		nx_p.push_back(p);
		nx_f.push_back(f);
	endfunction

	function automatic answer_t apply_request(mode_t mode, logic [63:0] s, logic [63:0] len,
			logic [7:0] prot, logic [15:0] fl);
		answer_t a;
		logic [63:0] e, rs, re, ms, me;
		logic [15:0] nf;
		bit any, placed, hit;
		a.st = ST_DONE;
		a.cnt = 7'(tbl_start.size());
		any = 0;
		placed = 0;
		if (mode == MODE_UNUSED || len == 0)
			return a;
		if (len > ADDR_MAX - s) begin
			a.st = ST_RANGE;
			return a;
		end
		e = s + len;
		foreach (tbl_start[i])
			if (tbl_start[i] < e && s < tbl_end[i])
				any = 1;
		nx_s.delete(); nx_e.delete(); nx_p.delete(); nx_f.delete();
		foreach (tbl_start[i]) begin
			rs = tbl_start[i];
			re = tbl_end[i];
			hit = rs < e && s < re;
			if (mode == MODE_MAP && !any && !placed && rs >= s) begin
				put(s, e, prot, fl);
				placed = 1;
			end
			if (!hit)
				put(rs, re, tbl_prot[i], tbl_flags[i]);
			else if (mode == MODE_UNMAP) begin
				if (rs < s)
					put(rs, s, tbl_prot[i], tbl_flags[i]);
				if (e < re)
					put(e, re, tbl_prot[i], tbl_flags[i]);
			end else begin
				nf = (mode == MODE_MAP) ? fl : tbl_flags[i];
				if (tbl_prot[i] == prot && tbl_flags[i] == nf)
					put(rs, re, tbl_prot[i], tbl_flags[i]);
				else begin
					ms = rs < s ? s : rs;
					me = re < e ? re : e;
					if (rs < s)
						put(rs, s, tbl_prot[i], tbl_flags[i]);
					put(ms, me, prot, nf);
					if (e < re)
						put(e, re, tbl_prot[i], tbl_flags[i]);
				end
			end
		end
		if (mode == MODE_MAP && !any && !placed)
			put(s, e, prot, fl);
		if (nx_s.size() > DEPTH) begin
			a.st = ST_FULL;
			return a;
		end
		tbl_start = nx_s;
		tbl_end = nx_e;
		tbl_prot = nx_p;
		tbl_flags = nx_f;
		a.cnt = 7'(tbl_start.size());
		return a;
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("** memory_region_attribute_table: FAILED **");
		$finish;
	end

	// receiver: stall pattern driven at the falling edge
	initial begin
		int phase;
		rsp.ready = 0;
		phase = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			phase++;
			if ((phase / 200) % 3 == 2)
				rsp.ready <= 1;
			else
				rsp.ready <= ($urandom_range(0, 99) < 60);
		end
	end

	always @(posedge clk) begin
		answer_t a;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending.size() == 0) begin
				$error("result with no request waiting");
				failed = 1;
			end else begin
				a = pending.pop_front();
				if (rsp.status !== a.st) begin
					$error("status expected %0d actual %0d", a.st, rsp.status);
					failed = 1;
				end
				if (rsp.region_count !== a.cnt) begin
					$error("region_count expected %0d actual %0d", a.cnt, rsp.region_count);
					failed = 1;
				end
			end
		end
	end

	task automatic send(req_row_t r);
		answer_t a;
		req.valid <= 1;
		req.mode <= r.mode;
		req.base_address <= r.base;
		req.range_length <= r.len;
		req.protection <= r.prot;
		req.map_flags <= r.flags;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		a = apply_request(r.mode, r.base, r.len, r.prot, r.flags);
		if (r.known && (a.st != r.st || a.cnt != r.cnt)) begin
			$error("directed row mismatch: status %0d/%0d count %0d/%0d",
				r.st, a.st, r.cnt, a.cnt);
			failed = 1;
		end
		pending.push_back(a);
	endtask

	task automatic gap_or_hold(ref int burst);
		if (burst > 0) begin
			burst--;
			return;
		end
		req.valid <= 0;
		repeat ($urandom_range(1, 6)) @(negedge clk);
		burst = $urandom_range(0, 12);
	endtask

	function automatic req_row_t row(mode_t m, logic [47:0] b, logic [47:0] l, logic [7:0] p,
			logic [15:0] f, bit k, status_t st, logic [6:0] c);
		req_row_t r;
		r.mode = m; r.base = b; r.len = l; r.prot = p; r.flags = f;
		r.known = k; r.st = st; r.cnt = c;
		return r;
	endfunction

	initial begin
		req_row_t dir [$];
		req_row_t r;
		int burst, pick;
		logic [47:0] b, l;
		req.valid = 0;
		req.mode = MODE_MAP;
		req.base_address = 0;
		req.range_length = 0;
		req.protection = 0;
		req.map_flags = 0;
		arst_n = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		dir.push_back(row(MODE_UNMAP, 48'h100, 48'h10, 0, 0, 1, ST_DONE, 0));
		dir.push_back(row(MODE_MAP, 48'h1000, 0, 8'hFF, 16'hFFFF, 1, ST_DONE, 0));
		dir.push_back(row(MODE_UNUSED, 48'h1000, 48'h10, 1, 1, 1, ST_DONE, 0));
		dir.push_back(row(MODE_MAP, '1, 48'h1, 1, 1, 1, ST_RANGE, 0));
		dir.push_back(row(MODE_MAP, 48'h1, '1, 1, 1, 1, ST_RANGE, 0));
		dir.push_back(row(MODE_MAP, 0, '1, 8'hFF, 16'hFFFF, 1, ST_DONE, 1));
		dir.push_back(row(MODE_MAP, 48'h1000, 48'h1000, 8'hFF, 16'hFFFF, 1, ST_DONE, 1));
		dir.push_back(row(MODE_PROTECT, 48'h1000, 48'h1000, 8'h11, 0, 1, ST_DONE, 3));
		dir.push_back(row(MODE_PROTECT, 48'h1000, 48'h1000, 8'h11, 0, 1, ST_DONE, 3));
		dir.push_back(row(MODE_MAP, 48'h1800, 48'h100, 8'h22, 16'hA5A5, 0, ST_DONE, 0));
		dir.push_back(row(MODE_UNMAP, 48'h1880, 48'h10, 0, 0, 0, ST_DONE, 0));
		dir.push_back(row(MODE_UNMAP, 0, '1, 0, 0, 1, ST_DONE, 0));
		dir.push_back(row(MODE_MAP, 48'h5000, 48'h100, 8'h01, 16'h0001, 1, ST_DONE, 1));
		dir.push_back(row(MODE_MAP, 48'h1000, 48'h100, 8'h02, 16'h0002, 1, ST_DONE, 2));
		dir.push_back(row(MODE_MAP, 48'h9000, 48'h100, 8'h03, 16'h0003, 1, ST_DONE, 3));
		dir.push_back(row(MODE_MAP, 48'h0, 48'hA000, 8'h04, 16'h0004, 1, ST_DONE, 3));
		dir.push_back(row(MODE_UNMAP, 48'h5040, 48'h40, 0, 0, 1, ST_DONE, 4));
		dir.push_back(row(MODE_UNMAP, 0, '1, 0, 0, 1, ST_DONE, 0));
		// fill to the limit with short regions, then overflow by an insert or a split
		for (int i = 0; i < DEPTH; i++)
			dir.push_back(row(MODE_MAP, 48'h100 * i, 48'h80, 8'h05, 16'h0005, 0, ST_DONE, 0));
		dir.push_back(row(MODE_MAP, 48'hFFFF_0000, 48'h10, 8'h06, 16'h6, 1, ST_FULL, 64));
		dir.push_back(row(MODE_PROTECT, 48'h110, 48'h10, 8'h07, 0, 1, ST_FULL, 64));
		dir.push_back(row(MODE_UNMAP, 48'h10, 48'h10, 0, 0, 1, ST_FULL, 64));
		dir.push_back(row(MODE_UNMAP, 0, '1, 0, 0, 1, ST_DONE, 0));

		burst = 0;
		foreach (dir[i]) begin
			@(negedge clk);
			send(dir[i]);
			@(negedge clk);
			req.valid <= 0;
			if (i % 5 == 4)
				repeat ($urandom_range(0, 4)) @(negedge clk);
		end

		for (int n = 0; n < 320; n++) begin
			pick = $urandom_range(0, 99);
			// mostly a small window so requests overlap and split
			b = 48'($urandom_range(0, 4095));
			l = 48'($urandom_range(1, 300));
			if (pick < 4) begin
				b = 48'({$urandom, $urandom});
				l = 48'({$urandom, $urandom});
			end else if (pick < 7)
				l = 0;
			else if (pick < 10)
				b = 48'(ADDR_MAX - 64'($urandom_range(0, 400)));
			r.mode = $urandom_range(0, 99) < 50 ? MODE_MAP
				: ($urandom_range(0, 9) < 6 ? MODE_PROTECT
				: ($urandom_range(0, 9) < 9 ? MODE_UNMAP : MODE_UNUSED));
			if (tbl_start.size() > 56 && $urandom_range(0, 3) == 0) begin
				r.mode = MODE_UNMAP;
				b = 0;
				l = 48'($urandom_range(200, 3000));
			end
			r.base = b;
			r.len = l;
			r.prot = $urandom_range(0, 3) == 0 ? 8'hFF : 8'($urandom_range(0, 3));
			r.flags = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 3));
			r.known = 0;
			@(negedge clk);
			send(r);
			@(negedge clk);
			gap_or_hold(burst);
		end
		req.valid <= 0;

		fork
			begin
				while (pending.size() != 0)
					@(posedge clk);
				repeat (400) @(posedge clk);
				last_seen = 1;
			end
			begin
				repeat (200_000) @(posedge clk);
			end
		join_any
		if (!last_seen) begin
			$display("** memory_region_attribute_table: FAILED **");
			$finish;
		end else begin
			if (!failed && pending.size() == 0)
				$display("** memory_region_attribute_table: PASSED **");
			else
				$display("** memory_region_attribute_table: FAILED **");
			$finish;
		end
	end

endmodule
